// ----- src/arbm_pkg.sv -----
// Shared types and constants for the address range breakpoint matcher.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package arbm_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int NUM_ZONES   = 4;
  localparam int ADDR_BITS   = 24;

  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 3;
  localparam int SZONE_W  = 3;
  localparam int AZONE_W  = 2;
  localparam int KINDS_W  = 3;
  localparam int AFIELD_W = 24;

  localparam logic [SZONE_W-1:0] ZONE_NONE = '0;

  typedef enum logic [FUNC_W-1:0] {
    FN_CHECK = 2'd0,
    FN_WRITE = 2'd1,
    FN_CLEAR = 2'd2
  } func_t;

  typedef struct packed {
    logic                 enabled;
    logic [SZONE_W-1:0]   zone;
    logic [ADDR_BITS-1:0] first;
    logic [ADDR_BITS-1:0] last;
    logic [KINDS_W-1:0]   kinds;
  } slot_t;

  typedef struct packed {
    logic             write;
    logic             clear;
    logic [IDX_W-1:0] idx;
    slot_t            slot;
  } tbl_cmd_t;

endpackage

`default_nettype wire

// ----- src/arbm_table.sv -----
// Breakpoint slot table: one register row per slot, written or cleared by command.
// Depends on arbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arbm_table (
  input  wire                                           clk,
  input  wire                                           rst,
  input  arbm_pkg::tbl_cmd_t                            cmd,
  output arbm_pkg::slot_t [arbm_pkg::NUM_ENTRIES-1:0]   slots
);
  import arbm_pkg::*;

  // Every index value matches a row, so a write always updates one slot.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      slots <= '0;
    end else if (cmd.write) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        if (cmd.idx == IDX_W'(k)) begin
          slots[k] <= cmd.slot;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/arbm_compare.sv -----
// Parallel range comparators: one per slot, results ORed into a single hit.
// Depends on arbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arbm_compare (
  input  arbm_pkg::slot_t [arbm_pkg::NUM_ENTRIES-1:0] slots,
  input  wire [arbm_pkg::AZONE_W-1:0]                 acc_zone,
  input  wire [arbm_pkg::ADDR_BITS-1:0]               acc_addr,
  input  wire [arbm_pkg::KINDS_W-1:0]                 acc_kinds,
  output logic                                        hit
);
  import arbm_pkg::*;

  logic [NUM_ENTRIES-1:0] match;
  logic [SZONE_W-1:0]     zone_m1 [NUM_ENTRIES];
  logic                   acc_zone_ok;

  assign acc_zone_ok = 32'(acc_zone) < NUM_ZONES;

  always_comb begin
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      zone_m1[k] = slots[k].zone - SZONE_W'(1);
      match[k]   = slots[k].enabled
                && (slots[k].zone != ZONE_NONE)
                && (32'(zone_m1[k]) < NUM_ZONES)
                && (zone_m1[k] == SZONE_W'(acc_zone))
                && (acc_addr >= slots[k].first)
                && (acc_addr <= slots[k].last)
                && (|(slots[k].kinds & acc_kinds));
    end
  end

  assign hit = acc_zone_ok && (|match);

endmodule

`default_nettype wire

// ----- src/address_range_breakpoint_match.sv -----
// Address range breakpoint matcher, top level.
// A check beat passes through the input register and then the result register, which shows its hit.
// Throughput: one beat per cycle while the input is not stalled; write and clear beats give no result.
// The input stage holds a check only while the result register is full and stalled.
// Reset clears the pipeline and every slot (disabled, unassigned). Depends on arbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module address_range_breakpoint_match (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire [arbm_pkg::FUNC_W-1:0]      func,
  input  wire [arbm_pkg::IDX_W-1:0]       entry_index,
  input  wire                             entry_enabled,
  input  wire [arbm_pkg::SZONE_W-1:0]     entry_zone,
  input  wire [arbm_pkg::AFIELD_W-1:0]    entry_start,
  input  wire [arbm_pkg::AFIELD_W-1:0]    entry_end,
  input  wire [arbm_pkg::KINDS_W-1:0]     entry_kinds,
  input  wire [arbm_pkg::AZONE_W-1:0]     access_zone,
  input  wire [arbm_pkg::AFIELD_W-1:0]    access_address,
  input  wire [arbm_pkg::KINDS_W-1:0]     access_kinds,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            hit
);
  import arbm_pkg::*;

  // Input register
  logic                 s1_valid;
  logic [FUNC_W-1:0]    s1_func;
  logic [IDX_W-1:0]     s1_idx;
  slot_t                s1_slot;
  logic [AZONE_W-1:0]   s1_zone;
  logic [ADDR_BITS-1:0] s1_addr;
  logic [KINDS_W-1:0]   s1_kinds;

  logic                 out_free;
  logic                 s1_go;
  logic                 s1_is_check;
  tbl_cmd_t             cmd;
  slot_t [NUM_ENTRIES-1:0] slots;
  logic                 cmp_hit;

  assign out_free    = !out_valid || !out_stall;
  assign s1_is_check = (s1_func == FN_CHECK);
  assign s1_go       = s1_valid && (!s1_is_check || out_free);
  assign in_stall    = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_func            <= func;
      s1_idx             <= entry_index;
      s1_slot.enabled    <= entry_enabled;
      s1_slot.zone       <= entry_zone;
      s1_slot.first      <= entry_start[ADDR_BITS-1:0];
      s1_slot.last       <= entry_end[ADDR_BITS-1:0];
      s1_slot.kinds      <= entry_kinds;
      s1_zone            <= access_zone;
      s1_addr            <= access_address[ADDR_BITS-1:0];
      s1_kinds           <= access_kinds;
    end
  end

  // Apply table updates as the beat leaves the input register
  always_comb begin
    cmd       = '0;
    cmd.idx   = s1_idx;
    cmd.slot  = s1_slot;
    case (s1_func)
      FN_WRITE: cmd.write = s1_go;
      FN_CLEAR: cmd.clear = s1_go;
      default:  cmd.write = 1'b0;
    endcase
  end

  arbm_table u_table (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .slots (slots)
  );

  arbm_compare u_compare (
    .slots     (slots),
    .acc_zone  (s1_zone),
    .acc_addr  (s1_addr),
    .acc_kinds (s1_kinds),
    .hit       (cmp_hit)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && s1_is_check;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      hit <= cmp_hit;
    end
  end

endmodule

`default_nettype wire

// ----- src/arbm_checker.sv -----
// Port-level checks for the breakpoint matcher, bound to the top level.
// Depends on arbm_pkg and address_range_breakpoint_match.
`timescale 1ns / 1ps
`default_nettype none

module arbm_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             in_valid,
  input wire                             in_stall,
  input wire [arbm_pkg::FUNC_W-1:0]      func,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire                             hit
);
  import arbm_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A fresh result comes from an accepted check beat.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && !rst && func == FN_CHECK, 2))
    else $error("result with no matching check beat");

  // Input backpressure only comes from a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

endmodule

bind address_range_breakpoint_match arbm_checker u_arbm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .func      (func),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit)
);

`default_nettype wire
